@@ hw/rtl/fmd_pkg.sv @@
// ----------------------------------------------------------------------------
// fmd_pkg: shared definitions for the Modbus ASCII frame decoder
// Widths, codes and the command record passed from the front to the back.
// ----------------------------------------------------------------------------
package fmd_pkg;

    localparam int MAX_HEX_CHARS = 512;
    localparam int HEX_W         = $clog2(MAX_HEX_CHARS + 2);
    localparam int MIN_CHARS     = 9;
    localparam int MIN_HEX_CHARS = 4;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_AW       = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW       = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [3:0] LETTER_ADJ = 4'd9;

    typedef enum logic [2:0] {
        ST_ACCEPTED  = 3'd0,
        ST_SHORT     = 3'd1,
        ST_NO_COLON  = 3'd2,
        ST_BAD_LEN   = 3'd3,
        ST_TOO_LONG  = 3'd4
    } frame_status_t;

    typedef enum logic {
        KIND_DATA   = 1'b0,
        KIND_STATUS = 1'b1
    } result_kind_t;

    typedef enum logic [3:0] {
        PH_WAIT     = 4'b0001,
        PH_HEX      = 4'b0010,
        PH_DONE     = 4'b0100,
        PH_NOCOLON  = 4'b1000
    } phase_t;

    typedef struct packed {
        logic          has_byte;
        logic [7:0]    data_byte;
        logic [7:0]    byte_index;
        logic          has_status;
        frame_status_t status;
        logic          checksum_ok;
        logic [7:0]    server_address;
        logic [8:0]    byte_count;
    } cmd_t;

endpackage

@@ hw/rtl/fmd_front.sv @@
// ----------------------------------------------------------------------------
// fmd_front: character intake and frame tracking
// Tracks the frame phase, counts characters, pairs hex digits into bytes and
// evaluates the end-of-buffer status: a command per byte and at buffer end.
// ----------------------------------------------------------------------------
module fmd_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    in_char,
    input  logic          end_of_buffer,
    output logic          cmd_valid,
    output fmd_pkg::cmd_t cmd
);

    fmd_pkg::phase_t                 phase_reg, phase_next;
    logic [3:0]                      total_reg, total_next;
    logic [fmd_pkg::HEX_W-1:0]       hex_reg, hex_next;
    logic [3:0]                      nibble_reg, nibble_next;
    logic [7:0]                      lrc_reg, lrc_next;
    logic [7:0]                      addr_reg, addr_next;
    logic [3:0]                      digit;
    logic [7:0]                      new_byte;
    logic [fmd_pkg::HEX_W-2:0]       half_next;
    logic                            emit_byte;
    fmd_pkg::frame_status_t          status;

    always_comb
    begin
        digit = (in_char >= fmd_pkg::CH_UPPER_A) ? (in_char[3:0] + fmd_pkg::LETTER_ADJ)
                                                 : in_char[3:0];
        new_byte    = {nibble_reg, digit};
        total_next  = (total_reg < 4'(fmd_pkg::MIN_CHARS)) ? total_reg + 4'd1 : total_reg;
        phase_next  = phase_reg;
        hex_next    = hex_reg;
        nibble_next = nibble_reg;
        lrc_next    = lrc_reg;
        addr_next   = addr_reg;
        emit_byte   = 1'b0;
        unique case (phase_reg)
            fmd_pkg::PH_WAIT:
            begin
                phase_next = (in_char == fmd_pkg::CH_COLON) ? fmd_pkg::PH_HEX
                                                            : fmd_pkg::PH_NOCOLON;
            end
            fmd_pkg::PH_HEX:
            begin
                if (in_char == fmd_pkg::CH_CR || in_char == fmd_pkg::CH_LF)
                begin
                    phase_next = fmd_pkg::PH_DONE;
                end
                else if (hex_reg < fmd_pkg::HEX_W'(fmd_pkg::MAX_HEX_CHARS))
                begin
                    hex_next = hex_reg + 1'b1;
                    if (!hex_reg[0])
                    begin
                        nibble_next = digit;
                    end
                    else
                    begin
                        emit_byte = 1'b1;
                        lrc_next  = lrc_reg + new_byte;
                        if (hex_reg[fmd_pkg::HEX_W-1:1] == '0)
                        begin
                            addr_next = new_byte;
                        end
                    end
                end
                else
                begin
                    hex_next = fmd_pkg::HEX_W'(fmd_pkg::MAX_HEX_CHARS + 1);
                end
            end
            fmd_pkg::PH_DONE, fmd_pkg::PH_NOCOLON:
            begin
                phase_next = phase_reg;
            end
            default:
            begin
                phase_next = fmd_pkg::PH_WAIT;
            end
        endcase

        half_next = hex_next[fmd_pkg::HEX_W-1:1];

        priority if (total_next < 4'(fmd_pkg::MIN_CHARS))
            status = fmd_pkg::ST_SHORT;
        else if (phase_next == fmd_pkg::PH_NOCOLON)
            status = fmd_pkg::ST_NO_COLON;
        else if (hex_next > fmd_pkg::HEX_W'(fmd_pkg::MAX_HEX_CHARS))
            status = fmd_pkg::ST_TOO_LONG;
        else if (hex_next[0] || hex_next < fmd_pkg::HEX_W'(fmd_pkg::MIN_HEX_CHARS))
            status = fmd_pkg::ST_BAD_LEN;
        else
            status = fmd_pkg::ST_ACCEPTED;

        cmd.has_byte       = emit_byte;
        cmd.data_byte      = new_byte;
        cmd.byte_index     = 8'(half_next - 1'b1);
        cmd.has_status     = end_of_buffer;
        cmd.status         = status;
        cmd.checksum_ok    = (status == fmd_pkg::ST_ACCEPTED) && (lrc_next == 8'd0);
        cmd.server_address = (status == fmd_pkg::ST_ACCEPTED) ? addr_next : 8'd0;
        cmd.byte_count     = (status == fmd_pkg::ST_ACCEPTED) ? 9'(half_next) : 9'd0;
        cmd_valid          = accept && (emit_byte || end_of_buffer);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= fmd_pkg::PH_WAIT;
            total_reg  <= '0;
            hex_reg    <= '0;
            nibble_reg <= '0;
            lrc_reg    <= '0;
            addr_reg   <= '0;
        end
        else if (accept)
        begin
            if (end_of_buffer)
            begin
                phase_reg  <= fmd_pkg::PH_WAIT;
                total_reg  <= '0;
                hex_reg    <= '0;
                nibble_reg <= '0;
                lrc_reg    <= '0;
                addr_reg   <= '0;
            end
            else
            begin
                phase_reg  <= phase_next;
                total_reg  <= total_next;
                hex_reg    <= hex_next;
                nibble_reg <= nibble_next;
                lrc_reg    <= lrc_next;
                addr_reg   <= addr_next;
            end
        end
    end

endmodule

@@ hw/rtl/fmd_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// fmd_cmd_fifo: command queue between front and back
// A small register queue that lets the intake and the result side stall
// independently of each other.
// ----------------------------------------------------------------------------
module fmd_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  fmd_pkg::cmd_t wr_data,
    input  logic          rd_en,
    output fmd_pkg::cmd_t rd_data,
    output logic          full,
    output logic          nonempty
);

    fmd_pkg::cmd_t                 mem_reg [fmd_pkg::FIFO_DEPTH];
    logic [fmd_pkg::FIFO_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [fmd_pkg::FIFO_CW-1:0]   count_reg, count_next;
    logic                          do_wr, do_rd;

    assign full     = (count_reg == fmd_pkg::FIFO_CW'(fmd_pkg::FIFO_DEPTH));
    assign nonempty = (count_reg != '0);
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && nonempty;
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

@@ hw/rtl/fmd_back.sv @@
// ----------------------------------------------------------------------------
// fmd_back: result expansion
// Holds one command and presents its data beat, its status beat, or both in
// turn on the result side.
// ----------------------------------------------------------------------------
module fmd_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_avail,
    input  fmd_pkg::cmd_t cmd_in,
    output logic          cmd_take,
    input  logic          pop,
    output logic          empty,
    output logic          result_kind,
    output logic [7:0]    data_byte,
    output logic [7:0]    byte_index,
    output logic [2:0]    frame_status,
    output logic          checksum_ok,
    output logic [7:0]    server_address,
    output logic [8:0]    byte_count,
    output logic          last_result
);

    fmd_pkg::cmd_t cmd_reg;
    logic          valid_reg;
    logic          byte_done_reg;
    logic          show_byte;
    logic          taken;
    logic          finish;

    assign show_byte = cmd_reg.has_byte && !byte_done_reg;
    assign taken     = pop && valid_reg;
    assign finish    = taken && !(show_byte && cmd_reg.has_status);
    assign cmd_take  = (!valid_reg || finish) && cmd_avail;
    assign empty     = !valid_reg;

    always_comb
    begin
        if (show_byte)
        begin
            result_kind    = fmd_pkg::KIND_DATA;
            data_byte      = cmd_reg.data_byte;
            byte_index     = cmd_reg.byte_index;
            frame_status   = fmd_pkg::ST_ACCEPTED;
            checksum_ok    = 1'b0;
            server_address = 8'd0;
            byte_count     = 9'd0;
            last_result    = !cmd_reg.has_status;
        end
        else
        begin
            result_kind    = fmd_pkg::KIND_STATUS;
            data_byte      = 8'd0;
            byte_index     = 8'd0;
            frame_status   = cmd_reg.status;
            checksum_ok    = cmd_reg.checksum_ok;
            server_address = cmd_reg.server_address;
            byte_count     = cmd_reg.byte_count;
            last_result    = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            cmd_reg <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            byte_done_reg <= 1'b0;
        end
        else
        begin
            if (cmd_take)
            begin
                valid_reg     <= 1'b1;
                byte_done_reg <= 1'b0;
            end
            else if (finish)
            begin
                valid_reg     <= 1'b0;
                byte_done_reg <= 1'b0;
            end
            else if (taken)
            begin
                byte_done_reg <= 1'b1;
            end
        end
    end

endmodule

@@ hw/rtl/modbus_ascii_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// modbus_ascii_frame_decoder: Modbus ASCII frame decoder with LRC check
//
//   Channel   Handshake     Beat contents
//   input     push / full   in_char, end_of_buffer
//   result    empty / pop   result_kind, data_byte, byte_index, frame_status,
//                           checksum_ok, server_address, byte_count, last_result
//
// One character is taken per cycle while full is low and updates intake state.
// Each character yields up to two result beats, delivered one per cycle while
// pop is asserted from the result register, so a character yielding two beats
// holds the result side for both; a four-entry queue absorbs the difference.
// Reset is asynchronous and active low and needs no clearing pass.
// A stalled result side fills the queue and then raises full.
// ----------------------------------------------------------------------------
module modbus_ascii_frame_decoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_char,
    input  logic       end_of_buffer,
    output logic       empty,
    input  logic       pop,
    output logic       result_kind,
    output logic [7:0] data_byte,
    output logic [7:0] byte_index,
    output logic [2:0] frame_status,
    output logic       checksum_ok,
    output logic [7:0] server_address,
    output logic [8:0] byte_count,
    output logic       last_result
);

    fmd_pkg::cmd_t front_cmd;
    fmd_pkg::cmd_t fifo_cmd;
    logic          front_valid;
    logic          fifo_nonempty;
    logic          fifo_take;
    logic          accept;

    assign accept = push && !full;

    fmd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .in_char       (in_char),
        .end_of_buffer (end_of_buffer),
        .cmd_valid     (front_valid),
        .cmd           (front_cmd)
    );

    fmd_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (front_valid),
        .wr_data  (front_cmd),
        .rd_en    (fifo_take),
        .rd_data  (fifo_cmd),
        .full     (full),
        .nonempty (fifo_nonempty)
    );

    fmd_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_avail      (fifo_nonempty),
        .cmd_in         (fifo_cmd),
        .cmd_take       (fifo_take),
        .pop            (pop),
        .empty          (empty),
        .result_kind    (result_kind),
        .data_byte      (data_byte),
        .byte_index     (byte_index),
        .frame_status   (frame_status),
        .checksum_ok    (checksum_ok),
        .server_address (server_address),
        .byte_count     (byte_count),
        .last_result    (last_result)
    );

endmodule
